@@ sv/barometric_sensor_compensation_unit_assert.svh @@
// assertion macros for the compensation unit checker
`ifndef BAROMETRIC_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
// implication checked every cycle outside reset
`define BSC_ASSERT_IMP(label, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define BSC_ASSERT_NXT(label, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/bsc_pkg.sv @@
// shared types, constants and codes for the compensation unit
package bsc_pkg;
  localparam logic [31:0] C_4000 = 32'd4000;
  localparam logic [31:0] C_3038 = 32'd3038;
  localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
  localparam logic [31:0] C_3791 = 32'd3791;
  localparam logic [31:0] C_32768 = 32'd32768;
  localparam logic [31:0] C_50000 = 32'd50000;
  localparam logic [31:0] C_SIGN = 32'h8000_0000;

  localparam logic [1:0] REG_TEMP = 2'd0;
  localparam logic [1:0] REG_PA = 2'd1;
  localparam logic [1:0] REG_PB = 2'd2;
  localparam logic [1:0] REG_OSS = 2'd3;

  typedef struct packed {
    logic        func;
    logic [23:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic               is_pressure;
    logic signed [15:0] temp_tenths_c;
    logic signed [31:0] pressure_pa;
    logic               div_by_zero;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] n;
    logic [31:0] d;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] q;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_T1, S_T2, S_T3, S_TDIV, S_TEND,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10,
    S_PDIV, S_P11, S_P12, S_P13, S_P14, S_P15, S_OUT
  } state_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction
endpackage

@@ sv/bsc_div.sv @@
// unsigned 32-bit restoring divider, one quotient bit per cycle
module bsc_div (
  input  logic              clk,
  input  logic              rst,
  input  bsc_pkg::div_req_t req,
  output bsc_pkg::div_rsp_t rsp
);
  import bsc_pkg::*;

  logic [31:0] quo, divisor;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy, done;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= 6'd32;
        quo     <= req.n;
        divisor <= req.d;
        rem     <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q    = quo;
endmodule

@@ sv/barometric_sensor_compensation_unit.sv @@
// top level: sequencer with one shared multiplier and an iterative divider
// Usage: write calibration over the cfg channel (cfg_index 0..3, cfg_data) while idle.
// Send a request on the in channel: func 0 temperature, 1 pressure, raw_sample.
// One result follows on the out channel for every accepted request.
// From the accepting edge to out_valid the sequencer runs its multiply steps
// and the bit-serial divider; when the divisor is zero the divider is skipped,
// for pressure with the steps after it. All products of the sequencer come
// from one shared 32x32 multiplier.
// The block takes one request at a time: in_ready is high only while idle, so
// a new request is taken at the earliest in the cycle after the result is taken.
// The result is held in an output register; while the receiver stalls the
// block keeps it and takes no new request until out_ready accepts it.
// Reset (rst, synchronous, active high) clears all calibration registers, the
// oversampling setting and the stored b5 to zero and drops out_valid.
// A pressure request before any temperature request uses b5 = 0.
// A zero divisor gives a zero result with div_by_zero set.
module barometric_sensor_compensation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bsc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import bsc_pkg::*;

  logic [63:0] temp_coeffs, press_coeffs_a;
  logic [31:0] press_coeffs_b;
  logic [1:0]  oss;
  logic [31:0] last_b5;

  state_t state, state_next;
  logic [23:0] raw;
  logic [31:0] a, b, c, e, f, g;   // scratch registers
  logic [31:0] mop_a, mop_b, prod;
  logic        dz;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
  assign ac5 = {16'd0, temp_coeffs[15:0]};
  assign ac6 = {16'd0, temp_coeffs[31:16]};
  assign mc  = sx16(temp_coeffs[47:32]);
  assign md  = sx16(temp_coeffs[63:48]);
  assign ac1 = sx16(press_coeffs_a[15:0]);
  assign ac2 = sx16(press_coeffs_a[31:16]);
  assign ac3 = sx16(press_coeffs_a[47:32]);
  assign ac4 = {16'd0, press_coeffs_a[63:48]};
  assign b1  = sx16(press_coeffs_b[15:0]);
  assign b2  = sx16(press_coeffs_b[31:16]);

  bsc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  // shared multiplier operand select
  always_comb begin
    mop_a = a;
    mop_b = a;
    case (state)
      S_T1:    begin mop_a = {16'd0, raw[15:0]} - ac6; mop_b = ac5; end
      S_P2:    begin mop_a = a; mop_b = a; end
      S_P3:    begin mop_a = b; mop_b = b2; end
      S_P4:    begin mop_a = ac2; mop_b = a; end
      S_P6:    begin mop_a = ac3; mop_b = a; end
      S_P7:    begin mop_a = b1; mop_b = b; end
      S_P8:    begin mop_a = ac4; mop_b = asr32(c + e + 32'd2, 5'd2) + C_32768; end
      S_P9:    begin mop_a = ({8'd0, raw} >> (4'd8 - {2'b0, oss})) - f;
                     mop_b = C_50000 >> oss; end
      S_P11:   begin mop_a = asr32(g, 5'd8); mop_b = asr32(g, 5'd8); end
      S_P12:   begin mop_a = a; mop_b = C_3038; end
      S_P13:   begin mop_a = C_M7357; mop_b = g; end
      default: begin mop_a = a; mop_b = a; end
    endcase
  end
  assign prod = 32'(mop_a * mop_b);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid && in_ready) state_next = in_data.func ? S_P1 : S_T1;
      S_T1:    state_next = S_T2;
      S_T2:    state_next = S_T3;
      S_T3:    state_next = (a + md == 32'd0) ? S_TEND : S_TDIV;
      S_TDIV:  if (drsp.done) state_next = S_TEND;
      S_TEND:  state_next = S_OUT;
      S_P1:    state_next = S_P2;
      S_P2:    state_next = S_P3;
      S_P3:    state_next = S_P4;
      S_P4:    state_next = S_P5;
      S_P5:    state_next = S_P6;
      S_P6:    state_next = S_P7;
      S_P7:    state_next = S_P8;
      S_P8:    state_next = S_P9;
      S_P9:    state_next = S_P10;
      S_P10:   state_next = (e == 32'd0) ? S_OUT : S_PDIV;
      S_PDIV:  if (drsp.done) state_next = S_P11;
      S_P11:   state_next = S_P12;
      S_P12:   state_next = S_P13;
      S_P13:   state_next = S_P14;
      S_P14:   state_next = S_P15;
      S_P15:   state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // divider launch
  always_comb begin
    dreq = '0;
    case (state)
      S_T3: begin
        dreq.start = (a + md) != 32'd0;
        dreq.n = mc[31] ? 32'd0 - (mc << 11) : (mc << 11);
        dreq.d = b[31] ? 32'd0 - b : b;
      end
      S_P10: begin
        dreq.start = e != 32'd0;
        dreq.n = g[31] ? g : (g << 1);
        dreq.d = e;
      end
      default: dreq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      temp_coeffs <= '0;
      press_coeffs_a <= '0;
      press_coeffs_b <= '0;
      oss <= '0;
      last_b5 <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_TEMP: temp_coeffs <= cfg_data;
          REG_PA:   press_coeffs_a <= cfg_data;
          REG_PB:   press_coeffs_b <= cfg_data[31:0];
          REG_OSS:  oss <= cfg_data[1:0];
          default:  ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          raw <= in_data.raw_sample;
          dz <= 1'b0;
          out_data <= out_item_t'({in_data.func, 49'd0});
        end
        S_T1: a <= prod;
        S_T2: begin a <= asr32(a, 5'd15); b <= asr32(a, 5'd15) + md; end
        S_T3: if (a + md == 32'd0) begin dz <= 1'b1; c <= 32'd0; end
        S_TDIV: if (drsp.done) c <= (mc[31] != b[31]) ? 32'd0 - drsp.q : drsp.q;
        S_TEND: begin
          last_b5 <= a + c;
          out_data.div_by_zero <= dz;
          out_data.temp_tenths_c <= dz ? 16'sd0 : 16'(asr32(a + c + 32'd8, 5'd4));
        end
        S_P1: a <= last_b5 - C_4000;             // b6
        S_P2: begin c <= a; b <= asr32(prod, 5'd12); end  // c keeps b6, b sq
        S_P3: e <= asr32(prod, 5'd11);
        S_P4: e <= e + asr32(prod, 5'd11);      // x3
        S_P5: f <= asr32(((ac1 * 32'd4 + e) << oss) + 32'd2, 5'd2);  // b3
        S_P6: c <= asr32(prod, 5'd13);
        S_P7: e <= asr32(prod, 5'd16);
        S_P8: e <= prod >> 15;                   // b4
        S_P9: g <= prod;                         // b7
        S_P10: if (e == 32'd0) out_data.div_by_zero <= 1'b1;
        S_PDIV: if (drsp.done) g <= g[31] ? (drsp.q << 1) : drsp.q;
        S_P11: a <= prod;
        S_P12: a <= asr32(prod, 5'd16);
        S_P13: b <= asr32(prod, 5'd16);
        S_P14: g <= g + asr32(a + b + C_3791, 5'd4);
        S_P15: out_data.pressure_pa <= g;
        S_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

@@ sv/bsc_checker.sv @@
// port-level checker for the compensation unit, bound to the top level
`include "barometric_sensor_compensation_unit_assert.svh"
module bsc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bsc_pkg::out_item_t out_data
);
  import bsc_pkg::*;

  `BSC_ASSERT_IMP(no_in_while_out, rst, out_valid, !in_ready)
  `BSC_ASSERT_NXT(busy_after_accept, rst, in_valid && in_ready, !in_ready)
  `BSC_ASSERT_NXT(out_holds, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `BSC_ASSERT_IMP(unused_zero, rst, out_valid && !out_data.is_pressure,
                  out_data.pressure_pa == 32'sd0)
endmodule

bind barometric_sensor_compensation_unit bsc_checker u_bsc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
